// ----- sv/rdx_pkg.sv -----
// rdx_pkg: shared constants, types and the twiddle table builder for the fft engine
// no dependencies

package rdx_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_LOG2     = $clog2(MAX_POINTS);
  localparam int ADDR_W       = MAX_LOG2;
  localparam int HALF_POINTS  = MAX_POINTS / 2;
  localparam int TW_ADDR_W    = MAX_LOG2 - 1;
  localparam int SAMPLE_W     = 16;
  localparam int DATA_W       = 26;
  localparam int TW_W         = 16;
  localparam int LG_W         = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE   = 1'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_PUT,
    ST_BF_READ,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WRP,
    ST_BF_WRQ
  } ctrl_state_t;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_SUM,
    WSEL_DIFF
  } wsel_t;

  typedef struct packed {
    logic                 wr_en;
    wsel_t                wr_sel;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr_a;
    logic [ADDR_W-1:0]    rd_addr_b;
    logic [TW_ADDR_W-1:0] tw_addr;
    logic                 inverse;
    logic                 mul_en;
    logic                 sum_en;
    logic                 out_load;
    logic [ADDR_W-1:0]    out_index;
    logic                 out_last;
    logic [LG_W-1:0]      out_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  typedef logic [2*TW_W-1:0] tw_table_t [HALF_POINTS];

  function automatic logic [63:0] series_q30(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] t;
    longint      sum;
    x2   = (x * x + (ONE_Q30 >> 1)) >> 30;
    term = odd ? x : ONE_Q30;
    sum  = longint'(term);
    for (int n = 1; n <= 7; n++) begin
      t = (term * x2 + (ONE_Q30 >> 1)) >> 30;
      if (odd) begin
        case (n)
          1: term = t / 6;
          2: term = t / 20;
          3: term = t / 42;
          4: term = t / 72;
          5: term = t / 110;
          6: term = t / 156;
          default: term = t / 210;
        endcase
      end else begin
        case (n)
          1: term = t / 2;
          2: term = t / 12;
          3: term = t / 30;
          4: term = t / 56;
          5: term = t / 90;
          6: term = t / 132;
          default: term = t / 182;
        endcase
      end
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic logic [TW_W-1:0] q30_to_q15(input logic [63:0] s);
    logic [63:0] r;
    r = (s + 64'd16384) >> 15;
    return (r > 64'd32767) ? TW_W'(32767) : r[TW_W-1:0];
  endfunction

  function automatic tw_table_t build_rom();
    tw_table_t   tab;
    logic [63:0] v;
    logic [63:0] a;
    logic        neg;
    logic        swap;
    logic [TW_W-1:0] s;
    logic [TW_W-1:0] c;
    logic [TW_W-1:0] t;
    for (int k = 0; k < HALF_POINTS; k++) begin
      v    = 64'(8 * k);
      neg  = 1'b0;
      swap = 1'b0;
      if (v > 64'(2 * MAX_POINTS)) begin
        v   = 64'(4 * MAX_POINTS) - v;
        neg = 1'b1;
      end
      if (v > 64'(MAX_POINTS)) begin
        v    = 64'(2 * MAX_POINTS) - v;
        swap = 1'b1;
      end
      a = (PI_Q30 * v + 64'(2 * MAX_POINTS)) / (4 * MAX_POINTS);
      s = q30_to_q15(series_q30(a, 1'b1));
      c = q30_to_q15(series_q30(a, 1'b0));
      if (swap) begin
        t = s;
        s = c;
        c = t;
      end
      tab[k] = {(neg ? -c : c), s};
    end
    return tab;
  endfunction

endpackage

// ----- sv/rdx_if.sv -----
// rdx_in_if and rdx_out_if: valid/ready channels of the fft engine
// depends on rdx_pkg

interface rdx_in_if import rdx_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [SAMPLE_W-1:0] sample_real;
  logic signed [SAMPLE_W-1:0] sample_imag;

  modport source(output valid, operation, sample_real, sample_imag, input ready);
  modport sink(input valid, operation, sample_real, sample_imag, output ready);
endinterface

interface rdx_out_if import rdx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        bin_index;
  logic signed [DATA_W-1:0] result_real;
  logic signed [DATA_W-1:0] result_imag;
  logic                     last_bin;

  modport source(output valid, bin_index, result_real, result_imag, last_bin, input ready);
  modport sink(input valid, bin_index, result_real, result_imag, last_bin, output ready);
endinterface

// ----- sv/rdx_ctrl.sv -----
// rdx_ctrl: sequencer for loads, butterfly passes and bin reads
// depends on rdx_pkg

module rdx_ctrl import rdx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_operation,
  output logic                  in_ready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_stat_t              stat,
  output dp_cmd_t               cmd
);

  ctrl_state_t          state_r, state_nxt;
  logic [LG_W-1:0]      size_r, size_nxt;
  logic                 inv_r, inv_nxt;
  logic [ADDR_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [ADDR_W-1:0]    read_cnt_r, read_cnt_nxt;
  logic                 frame_ready_r, frame_ready_nxt;
  logic [LG_W-1:0]      stage_r, stage_nxt;
  logic [TW_ADDR_W-1:0] bf_cnt_r, bf_cnt_nxt;
  logic [ADDR_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                 rd_last_r, rd_last_nxt;

  logic [LG_W-1:0]      lg;
  logic [ADDR_W:0]      n_pts;
  logic [ADDR_W-1:0]    n_last;
  logic [TW_ADDR_W-1:0] bf_last;
  logic                 accept;
  logic [ADDR_W-1:0]    load_val;
  logic [ADDR_W:0]      load_inc;
  logic [ADDR_W-1:0]    rev;
  logic [ADDR_W-1:0]    half_m;
  logic [ADDR_W-1:0]    bf_ext;
  logic [ADDR_W-1:0]    jj;
  logic [ADDR_W-1:0]    p_addr;
  logic [ADDR_W-1:0]    q_addr;
  logic [ADDR_W-1:0]    k_full;

  always_comb begin
    if (size_r == '0) lg = LG_W'(1);
    else if (size_r > LG_W'(MAX_LOG2)) lg = LG_W'(MAX_LOG2);
    else lg = size_r;
  end

  assign n_pts   = (ADDR_W+1)'(1) << lg;
  assign n_last  = ADDR_W'(n_pts - (ADDR_W+1)'(1));
  assign bf_last = TW_ADDR_W'(n_last >> 1);
  assign in_ready = (state_r == ST_IDLE);
  assign accept  = in_valid && in_ready;

  assign load_val = frame_ready_r ? '0 : load_cnt_r;
  assign load_inc = {1'b0, load_val} + (ADDR_W+1)'(1);

  always_comb begin
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int b = 0; b < ADDR_W; b++) r[ADDR_W-1-b] = load_val[b];
    rev = r >> (LG_W'(MAX_LOG2) - lg);
  end

  assign half_m = (ADDR_W'(1) << stage_r) - ADDR_W'(1);
  assign bf_ext = {1'b0, bf_cnt_r};
  assign jj     = bf_ext & half_m;
  assign p_addr = ((bf_ext & ~half_m) << 1) | jj;
  assign q_addr = p_addr | (ADDR_W'(1) << stage_r);
  assign k_full = jj << (LG_W'(MAX_LOG2 - 1) - stage_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_LOAD && load_inc == n_pts) state_nxt = ST_BF_READ;
        else if (accept && in_operation == OP_READ && frame_ready_r) state_nxt = ST_RD_PUT;
      end
      ST_RD_PUT:  if (stat.out_free) state_nxt = ST_IDLE;
      ST_BF_READ: state_nxt = ST_BF_MUL;
      ST_BF_MUL:  state_nxt = ST_BF_SUM;
      ST_BF_SUM:  state_nxt = ST_BF_WRP;
      ST_BF_WRP:  state_nxt = ST_BF_WRQ;
      ST_BF_WRQ: begin
        if (bf_cnt_r == bf_last && stage_r == lg - LG_W'(1)) state_nxt = ST_IDLE;
        else state_nxt = ST_BF_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counters and configuration
  always_comb begin
    size_nxt        = size_r;
    inv_nxt         = inv_r;
    load_cnt_nxt    = load_cnt_r;
    read_cnt_nxt    = read_cnt_r;
    frame_ready_nxt = frame_ready_r;
    stage_nxt       = stage_r;
    bf_cnt_nxt      = bf_cnt_r;
    rd_idx_nxt      = rd_idx_r;
    rd_last_nxt     = rd_last_r;
    if (cfg_we) begin
      if (cfg_index == CFG_SIZE_LOG2) size_nxt = cfg_wdata;
      else inv_nxt = cfg_wdata[0];
      load_cnt_nxt    = '0;
      read_cnt_nxt    = '0;
      frame_ready_nxt = 1'b0;
    end else if (state_r == ST_IDLE && accept) begin
      if (in_operation == OP_LOAD) begin
        frame_ready_nxt = 1'b0;
        read_cnt_nxt    = '0;
        if (load_inc == n_pts) begin
          load_cnt_nxt = '0;
          stage_nxt    = '0;
          bf_cnt_nxt   = '0;
        end else begin
          load_cnt_nxt = ADDR_W'(load_inc);
        end
      end else if (frame_ready_r) begin
        rd_idx_nxt  = read_cnt_r & n_last;
        rd_last_nxt = ((read_cnt_r & n_last) == n_last);
        if ((read_cnt_r & n_last) == n_last) begin
          frame_ready_nxt = 1'b0;
          read_cnt_nxt    = '0;
        end else begin
          read_cnt_nxt = read_cnt_r + ADDR_W'(1);
        end
      end
    end else if (state_r == ST_BF_WRQ) begin
      if (bf_cnt_r == bf_last) begin
        bf_cnt_nxt = '0;
        if (stage_r == lg - LG_W'(1)) frame_ready_nxt = 1'b1;
        else stage_nxt = stage_r + LG_W'(1);
      end else begin
        bf_cnt_nxt = bf_cnt_r + TW_ADDR_W'(1);
      end
    end
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.wr_sel    = WSEL_LOAD;
    cmd.inverse   = inv_r;
    cmd.out_index = rd_idx_r;
    cmd.out_last  = rd_last_r;
    cmd.out_shift = inv_r ? lg : '0;
    cmd.rd_addr_b = q_addr;
    cmd.tw_addr   = TW_ADDR_W'(k_full);
    case (state_r)
      ST_IDLE: begin
        cmd.wr_addr   = rev;
        cmd.rd_addr_a = read_cnt_r & n_last;
        if (accept && in_operation == OP_LOAD) cmd.wr_en = 1'b1;
        if (accept && in_operation == OP_READ && frame_ready_r) cmd.rd_en = 1'b1;
      end
      ST_RD_PUT: cmd.out_load = stat.out_free;
      ST_BF_READ: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = p_addr;
      end
      ST_BF_MUL: cmd.mul_en = 1'b1;
      ST_BF_SUM: cmd.sum_en = 1'b1;
      ST_BF_WRP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WSEL_SUM;
        cmd.wr_addr = p_addr;
      end
      ST_BF_WRQ: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WSEL_DIFF;
        cmd.wr_addr = q_addr;
      end
      default: cmd.wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      size_r        <= LG_W'(MAX_LOG2);
      inv_r         <= 1'b0;
      load_cnt_r    <= '0;
      read_cnt_r    <= '0;
      frame_ready_r <= 1'b0;
      stage_r       <= '0;
      bf_cnt_r      <= '0;
    end else begin
      state_r       <= state_nxt;
      size_r        <= size_nxt;
      inv_r         <= inv_nxt;
      load_cnt_r    <= load_cnt_nxt;
      read_cnt_r    <= read_cnt_nxt;
      frame_ready_r <= frame_ready_nxt;
      stage_r       <= stage_nxt;
      bf_cnt_r      <= bf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    rd_last_r <= rd_last_nxt;
  end

  a_ready_clears_load: assert property (@(posedge clk) disable iff (!rst_n)
    frame_ready_r |-> load_cnt_r == '0) else $error("load count not cleared with frame ready");

  a_ready_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(frame_ready_r) |-> $past(state_r) == ST_BF_WRQ)
    else $error("frame ready raised outside the last butterfly");

  a_bf_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BF_READ |-> bf_cnt_r <= bf_last && stage_r < lg)
    else $error("butterfly counters out of range");

endmodule

// ----- sv/rdx_dp.sv -----
// rdx_dp: sample memory, twiddle rom, complex butterfly and result register
// depends on rdx_pkg

module rdx_dp import rdx_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic signed [SAMPLE_W-1:0] in_real,
  input  logic signed [SAMPLE_W-1:0] in_imag,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [ADDR_W-1:0]          out_index,
  output logic signed [DATA_W-1:0]   bin_real,
  output logic signed [DATA_W-1:0]   bin_imag,
  output logic                       out_last
);

  localparam tw_table_t TW_ROM = build_rom();
  localparam int PROD_W = DATA_W + TW_W;
  localparam int V_W    = PROD_W + 1;
  localparam int S_W    = DATA_W + 3;

  logic [2*DATA_W-1:0] mem [MAX_POINTS];

  logic signed [DATA_W-1:0]   a_re_r, a_im_r, b_re_r, b_im_r;
  logic [2*TW_W-1:0]          tw_r;
  logic                       bypass_r;
  logic signed [PROD_W-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [DATA_W-1:0]   sum_re_r, sum_im_r, dif_re_r, dif_im_r;
  logic                       out_valid_r;
  logic [ADDR_W-1:0]          out_index_r;
  logic signed [DATA_W-1:0]   bin_real_r, bin_imag_r;
  logic                       out_last_r;

  logic signed [TW_W-1:0]     wr, wi;
  logic signed [V_W-1:0]      v_re_w, v_im_w;
  logic signed [S_W-1:0]      v_re, v_im;
  logic [2*DATA_W-1:0]        wdata;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [S_W-1:0] x);
    if (x > S_W'(2**(DATA_W-1) - 1)) return {1'b0, {(DATA_W-1){1'b1}}};
    if (x < -(S_W'(2**(DATA_W-1)))) return {1'b1, {(DATA_W-1){1'b0}}};
    return x[DATA_W-1:0];
  endfunction

  assign wr = tw_r[2*TW_W-1:TW_W];
  assign wi = cmd.inverse ? $signed(tw_r[TW_W-1:0]) : -$signed(tw_r[TW_W-1:0]);

  always_comb begin
    v_re_w = (V_W'(p_rr_r) - V_W'(p_ii_r) + V_W'(16384)) >>> 15;
    v_im_w = (V_W'(p_ri_r) + V_W'(p_ir_r) + V_W'(16384)) >>> 15;
    if (bypass_r) begin
      v_re = S_W'(b_re_r);
      v_im = S_W'(b_im_r);
    end else begin
      v_re = v_re_w[S_W-1:0];
      v_im = v_im_w[S_W-1:0];
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      WSEL_LOAD: wdata = {DATA_W'(in_real), DATA_W'(in_imag)};
      WSEL_SUM:  wdata = {sum_re_r, sum_im_r};
      WSEL_DIFF: wdata = {dif_re_r, dif_im_r};
      default:   wdata = {sum_re_r, sum_im_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr] <= wdata;
    if (cmd.rd_en) begin
      {a_re_r, a_im_r} <= mem[cmd.rd_addr_a];
      {b_re_r, b_im_r} <= mem[cmd.rd_addr_b];
      tw_r             <= TW_ROM[cmd.tw_addr];
      bypass_r         <= (cmd.tw_addr == '0);
    end
    if (cmd.mul_en) begin
      p_rr_r <= b_re_r * wr;
      p_ii_r <= b_im_r * wi;
      p_ri_r <= b_re_r * wi;
      p_ir_r <= b_im_r * wr;
    end
    if (cmd.sum_en) begin
      sum_re_r <= sat(S_W'(a_re_r) + v_re);
      sum_im_r <= sat(S_W'(a_im_r) + v_im);
      dif_re_r <= sat(S_W'(a_re_r) - v_re);
      dif_im_r <= sat(S_W'(a_im_r) - v_im);
    end
    if (cmd.out_load) begin
      out_index_r <= cmd.out_index;
      out_last_r  <= cmd.out_last;
      bin_real_r  <= a_re_r >>> cmd.out_shift;
      bin_imag_r  <= a_im_r >>> cmd.out_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign bin_real  = bin_real_r;
  assign bin_imag  = bin_imag_r;
  assign out_last  = out_last_r;

endmodule

// ----- sv/radix2_fft_engine.sv -----
// Radix-2 decimation-in-time FFT of up to 1024 complex Q1.15 points. Load items write
// samples in bit-reversed order, one per cycle while idle; the load that completes a
// frame starts log2(N) passes of N/2 butterflies, each run as read, multiply, sum,
// write p and write q on the single complex multiplier and the one-write-port sample
// memory, with the input held off. A read item does a memory read, then loads the
// result register once it is free; that register holds a result while the next item
// is taken. Inverse scaling by N is applied as a shift when a bin is read out.
// No clearing pass after reset. Top level; depends on rdx_pkg, rdx_if, rdx_ctrl, rdx_dp

module radix2_fft_engine import rdx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rdx_in_if.sink                in_ch,
  rdx_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rdx_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .stat         (stat),
    .cmd          (cmd)
  );

  rdx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_real   (in_ch.sample_real),
    .in_imag   (in_ch.sample_imag),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_index (out_ch.bin_index),
    .bin_real  (out_ch.result_real),
    .bin_imag  (out_ch.result_imag),
    .out_last  (out_ch.last_bin)
  );

endmodule

// ----- verif/fft_bin_checker.sv -----
// fft_bin_checker: watches the channels and configuration writes of the fft engine,
// predicts every bin a read returns and compares it with what the block delivers
// depends on rdx_pkg and rdx_if
`timescale 1ns / 1ps

module fft_bin_checker import rdx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rdx_in_if                     in_mon,
  rdx_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fails,
  output int                    pending
);

  typedef struct {
    logic [ADDR_W-1:0]        idx;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
  } bin_t;

  bin_t   bins_due[$];
  longint tw_cos [HALF_POINTS];
  longint tw_sin [HALF_POINTS];
  longint mem_re [MAX_POINTS];
  longint mem_im [MAX_POINTS];
  int     loaded;
  int     drained;
  logic   have_frame;
  logic [LG_W-1:0] size_reg;
  logic   inv_reg;

  function automatic logic [63:0] taylor(logic [63:0] x, logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] dv;
    longint      acc;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = odd ? x : (64'd1 << 30);
    acc  = longint'(term);
    for (int n = 1; n <= 7; n++) begin
      dv   = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = ((term * x2 + (64'd1 << 29)) >> 30) / dv;
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic longint to_q15(logic [63:0] s);
    logic [63:0] r;
    r = (s + 64'd16384) >> 15;
    return (r > 64'd32767) ? 64'sd32767 : longint'(r);
  endfunction

  function automatic int span_lg();
    int r;
    r = int'(size_reg);
    if (r < 1) r = 1;
    if (r > MAX_LOG2) r = MAX_LOG2;
    return r;
  endfunction

  function automatic longint clip(longint x);
    longint hi;
    hi = (64'sd1 <<< (DATA_W - 1)) - 1;
    return (x > hi) ? hi : ((x < -hi - 1) ? -hi - 1 : x);
  endfunction

  initial begin
    logic [63:0] v;
    logic [63:0] ang;
    logic        neg;
    logic        swp;
    longint      s;
    longint      c;
    longint      t;
    for (int k = 0; k < HALF_POINTS; k++) begin
      v   = 64'(8 * k);
      neg = 1'b0;
      swp = 1'b0;
      if (v > 64'(2 * MAX_POINTS)) begin
        v = 64'(4 * MAX_POINTS) - v;
        neg = 1'b1;
      end
      if (v > 64'(MAX_POINTS)) begin
        v = 64'(2 * MAX_POINTS) - v;
        swp = 1'b1;
      end
      ang = (64'd3373259426 * v + 64'(2 * MAX_POINTS)) / 64'(4 * MAX_POINTS);
      s = to_q15(taylor(ang, 1'b1));
      c = to_q15(taylor(ang, 1'b0));
      if (swp) begin
        t = s;
        s = c;
        c = t;
      end
      tw_cos[k] = neg ? -c : c;
      tw_sin[k] = s;
    end
  end

  task automatic transform();
    int     lg;
    int     n;
    int     p;
    int     q;
    int     k;
    longint wr;
    longint wi;
    longint vr;
    longint vi;
    lg = span_lg();
    n  = 1 << lg;
    for (int half = 1; half < n; half = half * 2) begin
      for (int i = 0; i < n; i += 2 * half) begin
        for (int j = 0; j < half; j++) begin
          p = i + j;
          q = p + half;
          k = (j * (MAX_POINTS / (2 * half))) % HALF_POINTS;
          if (k == 0) begin
            vr = mem_re[q];
            vi = mem_im[q];
          end else begin
            wr = tw_cos[k];
            wi = inv_reg ? tw_sin[k] : -tw_sin[k];
            vr = (mem_re[q] * wr - mem_im[q] * wi + 16384) >>> 15;
            vi = (mem_re[q] * wi + mem_im[q] * wr + 16384) >>> 15;
          end
          mem_re[q] = clip(mem_re[p] - vr);
          mem_im[q] = clip(mem_im[p] - vi);
          mem_re[p] = clip(mem_re[p] + vr);
          mem_im[p] = clip(mem_im[p] + vi);
        end
      end
    end
    if (inv_reg) begin
      for (int i = 0; i < n; i++) begin
        mem_re[i] = mem_re[i] >>> lg;
        mem_im[i] = mem_im[i] >>> lg;
      end
    end
  endtask

  task automatic take_item(logic op, logic signed [SAMPLE_W-1:0] sr,
                           logic signed [SAMPLE_W-1:0] si);
    int   lg;
    int   n;
    int   rev;
    int   val;
    bin_t b;
    lg = span_lg();
    n  = 1 << lg;
    if (op == OP_LOAD) begin
      val = loaded;
      if (have_frame) begin
        have_frame = 1'b0;
        drained = 0;
        loaded = 0;
        val = 0;
      end
      rev = 0;
      for (int i = 0; i < lg; i++) begin
        rev = (rev << 1) | (val & 1);
        val = val >> 1;
      end
      rev = rev & (n - 1);
      mem_re[rev] = longint'(sr);
      mem_im[rev] = longint'(si);
      loaded++;
      if (loaded >= n) begin
        transform();
        loaded = 0;
        drained = 0;
        have_frame = 1'b1;
      end
    end else if (have_frame) begin
      b.idx  = ADDR_W'(drained & (n - 1));
      b.re   = DATA_W'(mem_re[drained & (n - 1)]);
      b.im   = DATA_W'(mem_im[drained & (n - 1)]);
      b.last = ((drained & (n - 1)) == n - 1);
      bins_due.push_back(b);
      if (b.last) begin
        have_frame = 1'b0;
        drained = 0;
      end else begin
        drained++;
      end
    end
  endtask

  always @(posedge clk) begin
    bin_t e;
    if (!rst_n) begin
      loaded     = 0;
      drained    = 0;
      have_frame = 1'b0;
      size_reg   = LG_W'(10);
      inv_reg    = 1'b0;
      bins_due.delete();
      fails      = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SIZE_LOG2) size_reg = cfg_wdata[LG_W-1:0];
        else inv_reg = cfg_wdata[0];
        loaded = 0;
        drained = 0;
        have_frame = 1'b0;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (bins_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected bin transfer: bin %0d re %0d im %0d",
                     out_mon.bin_index, out_mon.result_real, out_mon.result_imag);
        end else begin
          e = bins_due.pop_front();
          if (e.idx !== out_mon.bin_index || e.re !== out_mon.result_real ||
              e.im !== out_mon.result_imag || e.last !== out_mon.last_bin) begin
            fails++;
            if (fails <= 10)
              $display("bin mismatch: exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
                       e.idx, e.re, e.im, e.last, out_mon.bin_index,
                       out_mon.result_real, out_mon.result_imag, out_mon.last_bin);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        take_item(in_mon.operation, in_mon.sample_real, in_mon.sample_imag);
    end
    pending = bins_due.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// tb_top: clock, reset and stimulus for the fft engine, with random idling on both sides;
// the checker beside the block predicts and compares, this module gives the verdict
// depends on rdx_pkg, rdx_if, radix2_fft_engine and fft_bin_checker
`timescale 1ns / 1ps

module tb_top;
  import rdx_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fails;
  int                    pending;
  int                    items;
  int                    cur_lg;
  logic                  calm;
  int                    hold_seq;
  int                    hold_seen;
  int                    hold_left;

  rdx_in_if  in_ch();
  rdx_out_if out_ch();

  radix2_fft_engine uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  fft_bin_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // receiver side, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_seen = hold_seq;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send(logic op, logic signed [SAMPLE_W-1:0] sr,
                      logic signed [SAMPLE_W-1:0] si);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.sample_real <= sr;
    in_ch.sample_imag <= si;
    do @(posedge clk); while (!in_ch.ready);
    items++;
  endtask

  // waits out results and any transform still running
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3 * (1 << cur_lg) * cur_lg + 20) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int r;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_SIZE_LOG2) begin
      r = int'(val);
      cur_lg = (r < 1) ? 1 : ((r > MAX_LOG2) ? MAX_LOG2 : r);
    end
  endtask

  task automatic load_frame(int n);
    for (int i = 0; i < n; i++) send(OP_LOAD, pick_sample(), pick_sample());
  endtask

  task automatic read_bins(int n);
    for (int i = 0; i < n; i++) send(OP_READ, pick_sample(), pick_sample());
  endtask

  initial begin
    int n;
    int kind;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.operation   = OP_LOAD;
    in_ch.sample_real = '0;
    in_ch.sample_imag = '0;
    calm     = 1'b0;
    hold_seq = 0;
    items    = 0;
    cur_lg   = MAX_LOG2;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size below range acts as two points
    set_reg(CFG_SIZE_LOG2, 4'd0);
    set_reg(CFG_INVERSE, 4'd0);
    send(OP_READ, 16'sh0, 16'sh0);
    send(OP_LOAD, 16'sh7fff, 16'sh8000);
    send(OP_READ, 16'sh0, 16'sh0);
    send(OP_LOAD, 16'sh8000, 16'sh7fff);
    send(OP_READ, 16'shffff, 16'shffff);
    send(OP_READ, 16'sh0, 16'sh0);
    send(OP_READ, 16'sh0, 16'sh0);
    send(OP_LOAD, 16'sh7fff, 16'sh7fff);
    send(OP_LOAD, 16'sh7fff, 16'sh7fff);
    send(OP_READ, 16'sh0, 16'sh0);
    send(OP_LOAD, 16'sh8000, 16'sh8000);
    send(OP_LOAD, 16'sh8000, 16'sh0);
    read_bins(2);
    settle();
    set_reg(CFG_SIZE_LOG2, 4'd2);
    set_reg(CFG_INVERSE, 4'd1);
    for (int i = 0; i < 4; i++) send(OP_LOAD, 16'sh8000, 16'sh8000);
    read_bins(5);
    settle();

    // size above range acts as the full length, so a short frame stays incomplete
    set_reg(CFG_SIZE_LOG2, 4'd15);
    set_reg(CFG_INVERSE, 4'd0);
    load_frame(40);
    read_bins(4);
    settle();

    // receiver holds off while reads keep coming
    set_reg(CFG_SIZE_LOG2, 4'd5);
    calm = 1'b1;
    load_frame(32);
    hold_seq++;
    read_bins(32);
    calm = 1'b0;
    settle();

    while (items < 850) begin
      n = $urandom_range(9);
      set_reg(CFG_SIZE_LOG2, (n < 8 || items > 500) ? 4'($urandom_range(1, 5))
                                                     : 4'($urandom_range(6, 7)));
      set_reg(CFG_INVERSE, 4'($urandom_range(1)));
      n = 1 << cur_lg;
      calm = ($urandom_range(7) == 0);
      kind = $urandom_range(9);
      if (kind < 7) begin
        load_frame(n);
        read_bins(n + $urandom_range(1));
        if ($urandom_range(1)) begin
          load_frame(n);
          read_bins($urandom_range(n));
          load_frame(n);
          read_bins(n);
        end
      end else if (kind == 7) begin
        read_bins($urandom_range(2));
        load_frame($urandom_range(n - 1));
        read_bins($urandom_range(2));
        load_frame(n);
        read_bins(n);
      end else begin
        for (int i = 0; i < 3 * n; i++)
          send(1'($urandom_range(1)), pick_sample(), pick_sample());
      end
      calm = 1'b0;
      settle();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/rdx_pkg.sv
sv/rdx_if.sv
sv/rdx_ctrl.sv
sv/rdx_dp.sv
sv/radix2_fft_engine.sv
verif/fft_bin_checker.sv
verif/tb_top.sv
